// File: src/rs816_pkg.sv
// Package with shared widths, job kinds and the job record of the range stretch unit.
`default_nettype none
package rs816_pkg;

    localparam int PIX_W       = 16;
    localparam int MAP_W       = 8;
    localparam int SPAN_W      = PIX_W + 1;
    localparam int OUT_W       = MAP_W + 2 * PIX_W;
    localparam int QUOT_STEPS  = MAP_W;
    localparam int STEP_W      = $clog2(QUOT_STEPS);
    localparam int DIRECT_SPAN = 1 << MAP_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = QUEUE_AW + 1;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_MAP     = 1'b1;

    typedef enum logic {
        JOB_DIRECT,
        JOB_DIVIDE
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [PIX_W-1:0]   operand;
        logic [SPAN_W-1:0]  span;
        logic [PIX_W-1:0]   range_low;
        logic [PIX_W-1:0]   range_high;
    } rs816_job_t;

endpackage
`default_nettype wire

// File: src/range_stretch_16_to_8_unit.sv
// Top level of the 16-bit to 8-bit min/max contrast stretch unit.
`default_nettype none
// Measure words (func 0) update the frame minimum and maximum, restarting on
// first_of_frame; map words (func 1) come out as the pixel's offset from the
// minimum, scaled to 8 bits when the span is over 256, and every result
// word also carries the range. The front end takes one word per cycle while
// its four-entry job queue has room. While its output is taken, the back end
// emits one result per cycle for measure words, pixels outside the range and
// spans of at most 256; a map pixel over a wider span runs through its
// 8-step restoring divider; the next job waits until its quotient is out.
module range_stretch_16_to_8_unit
    import rs816_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,   // pixel
    input  wire logic [1:0]       s_tuser,   // func, first_of_frame
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // mapped, range_low, range_high
);

    rs816_job_t push_job;
    rs816_job_t head_job;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    rs816_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_full   (q_full)
    );

    rs816_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    rs816_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// File: src/rs816_front.sv
// Front end: accepts words, tracks the frame range and classifies map pixels into jobs.
`default_nettype none
module rs816_front
    import rs816_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,   // pixel
    input  wire logic [1:0]       s_tuser,   // func, first_of_frame
    output logic                  q_push,
    output rs816_job_t            q_job,
    input  wire logic             q_full
);

    logic              func;
    logic              first;
    logic [PIX_W-1:0]  pixel;
    logic [PIX_W-1:0]  low_seen_reg;
    logic [PIX_W-1:0]  low_seen_next;
    logic [PIX_W-1:0]  high_seen_reg;
    logic [PIX_W-1:0]  high_seen_next;
    logic [SPAN_W-1:0] span;
    logic              in_range;

    assign func     = s_tuser[0];
    assign first    = s_tuser[1];
    assign pixel    = s_tdata;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    assign span     = {1'b0, high_seen_reg} - {1'b0, low_seen_reg} + SPAN_W'(1);
    assign in_range = (low_seen_reg <= high_seen_reg) && (pixel >= low_seen_reg)
                      && (pixel <= high_seen_reg);

    always_comb begin
        low_seen_next  = low_seen_reg;
        high_seen_next = high_seen_reg;
        if (func == FUNC_MEASURE) begin
            if (first) begin
                low_seen_next  = pixel;
                high_seen_next = pixel;
            end else begin
                if (pixel < low_seen_reg) begin
                    low_seen_next = pixel;
                end
                if (pixel > high_seen_reg) begin
                    high_seen_next = pixel;
                end
            end
        end

        q_job.kind       = JOB_DIRECT;
        q_job.operand    = '0;
        q_job.span       = span;
        q_job.range_low  = low_seen_next;
        q_job.range_high = high_seen_next;
        if ((func == FUNC_MAP) && in_range) begin
            q_job.operand = pixel - low_seen_reg;
            if (span > SPAN_W'(DIRECT_SPAN)) begin
                q_job.kind = JOB_DIVIDE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_seen_reg  <= '1;
            high_seen_reg <= '0;
        end else if (q_push) begin
            low_seen_reg  <= low_seen_next;
            high_seen_reg <= high_seen_next;
        end
    end

endmodule
`default_nettype wire

// File: src/rs816_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module rs816_queue
    import rs816_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire rs816_job_t push_job,
    output logic            full,
    input  wire logic       pop,
    output rs816_job_t      head_job,
    output logic            empty
);

    rs816_job_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/rs816_back.sv
// Back end: runs the restoring divider for wide spans and holds the output word.
`default_nettype none
module rs816_back
    import rs816_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rs816_job_t       head_job,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // mapped, range_low, range_high
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [OUT_W-1:0]   m_data_reg;
    logic [OUT_W-1:0]   m_data_next;
    logic [SPAN_W-1:0]  rem_reg;
    logic [SPAN_W-1:0]  rem_next;
    logic [SPAN_W-1:0]  span_reg;
    logic [SPAN_W-1:0]  span_next;
    logic [MAP_W-1:0]   quot_reg;
    logic [MAP_W-1:0]   quot_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [PIX_W-1:0]   low_reg;
    logic [PIX_W-1:0]   low_next;
    logic [PIX_W-1:0]   high_reg;
    logic [PIX_W-1:0]   high_next;
    logic               out_free;
    logic [SPAN_W-1:0]  shifted;
    logic               fits;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign shifted  = {rem_reg[PIX_W-1:0], 1'b0};
    assign fits     = (shifted >= span_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rem_next     = rem_reg;
        span_next    = span_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    if (head_job.kind == JOB_DIVIDE) begin
                        rem_next   = {1'b0, head_job.operand};
                        span_next  = head_job.span;
                        quot_next  = '0;
                        step_next  = '0;
                        low_next   = head_job.range_low;
                        high_next  = head_job.range_high;
                        state_next = ST_DIV;
                    end else begin
                        m_data_next  = {head_job.range_high, head_job.range_low,
                                        head_job.operand[MAP_W-1:0]};
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = fits ? (shifted - span_reg) : shifted;
                quot_next = {quot_reg[MAP_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUOT_STEPS - 1)) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    m_data_next  = {high_reg, low_reg, quot_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            rem_reg     <= rem_next;
            span_reg    <= span_next;
            quot_reg    <= quot_next;
            step_reg    <= step_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

    // The partial remainder always stays below the divisor.
    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder reached the span");

    // A job is taken from the queue only when the back end is free.
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE) && !q_empty)
        else $error("job popped while the back end was busy");

    // The step counter has wrapped once all quotient bits are done.
    a_steps_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> (step_reg == '0))
        else $error("divider left early");

    // Leaving the divide states always loads a new output word.
    a_wait_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) && out_free |=> m_valid_reg)
        else $error("finished quotient was not presented");

endmodule
`default_nettype wire

// File: tb/tb_range_stretch_16_to_8_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 16-bit to 8-bit min/max range stretch unit.
module tb_range_stretch_16_to_8_unit;
    import rs816_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [PIX_W-1:0] range_high;
        logic [PIX_W-1:0] range_low;
        logic [MAP_W-1:0] mapped;
    } stretch_word_t;

    class stretch_scoreboard;
        logic [PIX_W-1:0] frame_low;
        logic [PIX_W-1:0] frame_high;
        stretch_word_t    words_due[$];
        int errors;
        int words_in;
        int words_out;
        int map_words;
        int divided_words;
        int outside_words;

        function new();
            frame_low     = '1;
            frame_high    = '0;
            errors        = 0;
            words_in      = 0;
            words_out     = 0;
            map_words     = 0;
            divided_words = 0;
            outside_words = 0;
        endfunction

        function logic [MAP_W-1:0] stretch_pixel(logic [PIX_W-1:0] px);
            logic [SPAN_W-1:0]      span;
            logic [PIX_W-1:0]       offset;
            logic [PIX_W+MAP_W-1:0] scaled;
            if (frame_low > frame_high || px < frame_low || px > frame_high) begin
                outside_words++;
                return '0;
            end
            span   = {1'b0, frame_high} - {1'b0, frame_low} + 1'b1;
            offset = px - frame_low;
            if (span <= DIRECT_SPAN) begin
                return offset[MAP_W-1:0];
            end
            divided_words++;
            scaled = {offset, {MAP_W{1'b0}}} / span;
            return scaled[MAP_W-1:0];
        endfunction

        function void note_word(logic fn, logic ff, logic [PIX_W-1:0] px);
            stretch_word_t due;
            words_in++;
            due.mapped = '0;
            if (fn == FUNC_MEASURE) begin
                if (ff) begin
                    frame_low  = px;
                    frame_high = px;
                end else begin
                    if (px < frame_low) begin
                        frame_low = px;
                    end
                    if (px > frame_high) begin
                        frame_high = px;
                    end
                end
            end else begin
                map_words++;
                due.mapped = stretch_pixel(px);
            end
            due.range_low  = frame_low;
            due.range_high = frame_high;
            words_due.insert(words_due.size(), due);
        endfunction

        function void check_word(stretch_word_t got);
            stretch_word_t due;
            words_out++;
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with nothing expected", $time, got);
                return;
            end
            due = words_due.pop_front();
            if (got.mapped !== due.mapped) begin
                errors++;
                $display("%0t: mapped expected %0d, got %0d", $time, due.mapped, got.mapped);
            end
            if (got.range_low !== due.range_low) begin
                errors++;
                $display("%0t: range_low expected %0d, got %0d",
                         $time, due.range_low, got.range_low);
            end
            if (got.range_high !== due.range_high) begin
                errors++;
                $display("%0t: range_high expected %0d, got %0d",
                         $time, due.range_high, got.range_high);
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata;   // pixel
    logic [1:0]       s_tuser;   // func, first_of_frame
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;   // mapped, range_low, range_high

    logic hold_active = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   words_sent = 0;
    event hold_request;

    stretch_scoreboard sb = new();

    range_stretch_16_to_8_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_request);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_word(s_tuser[0], s_tuser[1], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
            end
        end
    end

    task automatic send_word(input logic fn, input logic ff, input logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {ff, fn};
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
        words_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_frame();
        int lo;
        int hi;
        int spread;
        int kind;
        int n_measure;
        int n_map;
        int lo_at;
        int hi_at;
        int px;
        int pick;
        logic ff;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            spread = $urandom_range(0, 255);
        end else if (kind == 4) begin
            spread = $urandom_range(254, 257);
        end else if (kind == 5) begin
            spread = 65535;
        end else begin
            spread = $urandom_range(256, 65535);
        end
        lo = $urandom_range(0, 65535 - spread);
        hi = lo + spread;
        n_measure = $urandom_range(1, 10);
        lo_at = $urandom_range(0, n_measure - 1);
        hi_at = $urandom_range(0, n_measure - 1);
        for (int i = 0; i < n_measure; i++) begin
            px = $urandom_range(lo, hi);
            if (i == hi_at) begin
                px = hi;
            end
            if (i == lo_at) begin
                px = lo;
            end
            ff = (i == 0) && ($urandom_range(0, 9) != 0);
            send_word(FUNC_MEASURE, ff, px[PIX_W-1:0]);
        end
        n_map = $urandom_range(1, 16);
        for (int i = 0; i < n_map; i++) begin
            pick = $urandom_range(0, 19);
            px = $urandom_range(lo, hi);
            if (pick == 0) begin
                px = $urandom_range(0, 65535);
            end else if (pick == 1) begin
                px = lo;
            end else if (pick == 2) begin
                px = hi;
            end else if (pick == 3 && lo > 0) begin
                px = lo - 1;
            end else if (pick == 4 && hi < 65535) begin
                px = hi + 1;
            end
            ff = ($urandom_range(0, 7) == 0);
            send_word(FUNC_MAP, ff, px[PIX_W-1:0]);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      PIX_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        #3_000_000;
        $display("range_stretch_16_to_8_unit regression: fail");
        $finish;
    end

    initial begin
        int target;
        bit hold_done;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Maps before any measure fall outside the empty reset range.
        send_word(FUNC_MAP, 1'b0, 16'h0000);
        send_word(FUNC_MAP, 1'b0, 16'hFFFF);
        send_word(FUNC_MAP, 1'b1, 16'd1234);
        // Widening from reset without a frame start.
        send_word(FUNC_MEASURE, 1'b0, 16'd1000);
        send_word(FUNC_MAP, 1'b0, 16'd1000);
        send_word(FUNC_MEASURE, 1'b0, 16'd1255);
        send_word(FUNC_MAP, 1'b0, 16'd1255);
        send_word(FUNC_MAP, 1'b0, 16'd1100);
        send_word(FUNC_MEASURE, 1'b0, 16'd1256);
        send_word(FUNC_MAP, 1'b0, 16'd1256);
        send_word(FUNC_MAP, 1'b0, 16'd999);
        send_word(FUNC_MAP, 1'b0, 16'd1257);
        // Full 16-bit span.
        send_word(FUNC_MEASURE, 1'b1, 16'hFFFF);
        send_word(FUNC_MEASURE, 1'b0, 16'h0000);
        send_word(FUNC_MAP, 1'b0, 16'hFFFF);
        send_word(FUNC_MAP, 1'b0, 16'h0000);
        send_word(FUNC_MAP, 1'b0, 16'h8000);
        send_word(FUNC_MAP, 1'b1, 16'd40000);
        // Single-value frame at zero.
        send_word(FUNC_MEASURE, 1'b1, 16'h0000);
        send_word(FUNC_MAP, 1'b0, 16'h0000);
        send_word(FUNC_MAP, 1'b0, 16'h0001);
        send_word(FUNC_MEASURE, 1'b1, 16'hAAAA);
        send_word(FUNC_MEASURE, 1'b0, 16'h5555);
        send_word(FUNC_MAP, 1'b0, 16'hFFFF);
        send_word(FUNC_MAP, 1'b0, 16'h8000);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 16 : 0;
            recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 16 : 0;
            target = words_sent + 257;
            hold_done = 1'b0;
            while (words_sent < target) begin
                if (!hold_done && words_sent >= target - 200 && (phase == 0 || phase == 2)) begin
                    hold_done = 1'b1;
                    -> hold_request;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_frame();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0t: %0d expected result words never arrived, oldest %h",
                     $time, sb.pending(), sb.words_due[0]);
        end
        $display("Summary: %0d words in, %0d results checked, %0d map words,",
                 sb.words_in, sb.words_out, sb.map_words);
        $display("%0d divided, %0d out of range; free flow, sender gaps, receiver stalls,",
                 sb.divided_words, sb.outside_words);
        $display("both at once, and long output holds were covered.");
        if (sb.errors == 0) begin
            $display("range_stretch_16_to_8_unit regression: pass");
        end else begin
            $display("range_stretch_16_to_8_unit regression: fail");
        end
        $finish;
    end

endmodule
